/* src/lws_pkg.sv */
// Shared types and constants of the line word search block.
`timescale 1ns / 1ps
package lws_pkg;

    // Operation codes for a classified word travelling from front to back.
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOI  = 2'd2;

    // Input kind codes.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Configuration register indexes.
    localparam logic CFG_PATTERN_BYTES  = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    localparam int PATTERN_BITS = 64;
    localparam int LENGTH_BITS  = 4;
    localparam int LINE_NUMBER_BITS = 32;

    // Depth of the queue between front and back, a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [QUEUE_PTR_BITS-1:0] t_qptr;
    typedef logic [QUEUE_PTR_BITS:0]   t_qcount;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] text_byte;
    } t_op_word;

endpackage

/* src/lws_front.sv */
// Front end: accepts input words and classifies them into operations.
`timescale 1ns / 1ps
module lws_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_text_byte,
    output logic              o_push,
    output lws_pkg::t_op_word o_word,
    input  logic              i_push_ready
);
    import lws_pkg::*;

    logic     r_fv;
    t_op_word r_fword;
    logic     n_fv;
    t_op_word n_fword;
    logic     accept;

    assign o_ready = !r_fv || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_fv;
    assign o_word  = r_fword;

    always_comb begin
        n_fv    = r_fv;
        n_fword = r_fword;
        if (r_fv && i_push_ready) begin
            n_fv = 1'b0;
        end
        if (accept) begin
            n_fv = 1'b1;
            n_fword.text_byte = i_text_byte;
            if (i_kind == KIND_END) begin
                n_fword.op = OP_EOI;
            end else if (i_text_byte == NEWLINE_BYTE) begin
                n_fword.op = OP_EOL;
            end else begin
                n_fword.op = OP_CHAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
        r_fword <= n_fword;
    end

endmodule

/* src/lws_queue.sv */
// Short first-in first-out queue of classified words.
`timescale 1ns / 1ps
module lws_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lws_pkg::t_op_word i_word,
    output logic              o_push_ready,
    output logic              o_valid,
    output lws_pkg::t_op_word o_word,
    input  logic              i_pop
);
    import lws_pkg::*;

    t_op_word r_mem [QUEUE_DEPTH];
    t_qptr    r_wptr;
    t_qptr    r_rptr;
    t_qcount  r_count;
    logic     do_push;
    logic     do_pop;

    assign o_push_ready = (r_count != t_qcount'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_word       = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

/* src/lws_back.sv */
// Back end: window compare, line tracking, line counter and result register.
`timescale 1ns / 1ps
module lws_back #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int LINE_COUNT_BITS   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [lws_pkg::PATTERN_BITS-1:0]      i_cfg_data,
    input  logic                                  i_q_valid,
    input  lws_pkg::t_op_word                     i_q_word,
    output logic                                  o_q_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [lws_pkg::LINE_NUMBER_BITS-1:0]  o_line_number
);
    import lws_pkg::*;

    localparam int WINW = 8 * MAX_PATTERN_BYTES;
    localparam int CW   = $clog2(MAX_PATTERN_BYTES + 1);

    logic [PATTERN_BITS-1:0]     r_pattern;
    logic [LENGTH_BITS-1:0]      r_plen;
    logic [WINW-1:0]             r_win;
    logic [CW-1:0]               r_cnt;
    logic                        r_has;
    logic [LINE_COUNT_BITS-1:0]  r_lines;
    logic                        r_out_valid;
    logic [LINE_NUMBER_BITS-1:0] r_out_line;

    logic [WINW-1:0]             n_win;
    logic [CW-1:0]               n_cnt;
    logic                        n_has;
    logic [LINE_COUNT_BITS-1:0]  n_lines;
    logic                        n_out_valid;
    logic [LINE_NUMBER_BITS-1:0] n_out_line;

    logic [WINW-1:0]             win_shift;
    logic [CW-1:0]               cnt_inc;
    logic [LENGTH_BITS-1:0]      eff4;
    logic [CW-1:0]               eff;
    logic [MAX_PATTERN_BYTES-1:0] hit;
    logic                        match;
    logic [LINE_COUNT_BITS-1:0]  lines_inc;
    logic                        slot_free;

    assign slot_free     = !r_out_valid || i_ready;
    assign o_q_pop       = i_q_valid && slot_free;
    assign o_valid       = r_out_valid;
    assign o_line_number = r_out_line;

    // Newest byte enters at the top of the window.
    assign win_shift = (r_win >> 8) | (WINW'(i_q_word.text_byte) << (WINW - 8));
    assign cnt_inc   = (r_cnt == CW'(MAX_PATTERN_BYTES)) ? r_cnt : r_cnt + 1'b1;
    assign lines_inc = (r_lines == '1) ? r_lines : r_lines + 1'b1;

    // Length zero acts as one; lengths beyond the window act as the window.
    always_comb begin
        if (r_plen == '0) begin
            eff4 = LENGTH_BITS'(1);
        end else if (r_plen > LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
            eff4 = LENGTH_BITS'(MAX_PATTERN_BYTES);
        end else begin
            eff4 = r_plen;
        end
    end
    assign eff = CW'(eff4);

    for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cmp
        assign hit[g] = (win_shift[WINW-1 -: 8*(g+1)] == r_pattern[8*(g+1)-1:0])
                        && (eff == CW'(g + 1));
    end
    assign match = (|hit) && (cnt_inc >= eff);

    always_comb begin
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_has       = r_has;
        n_lines     = r_lines;
        n_out_valid = r_out_valid;
        n_out_line  = r_out_line;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop) begin
            case (i_q_word.op)
                OP_CHAR: begin
                    n_win = win_shift;
                    n_cnt = cnt_inc;
                    if (match) begin
                        n_has = 1'b1;
                    end
                end
                OP_EOL: begin
                    n_lines = lines_inc;
                    n_cnt   = '0;
                    n_has   = 1'b0;
                    if (r_has) begin
                        n_out_valid = 1'b1;
                        n_out_line  = LINE_NUMBER_BITS'(lines_inc);
                    end
                end
                OP_EOI: begin
                    // A non-empty final line is closed before everything clears.
                    if (r_cnt != '0 && r_has) begin
                        n_out_valid = 1'b1;
                        n_out_line  = LINE_NUMBER_BITS'(lines_inc);
                    end
                    n_lines = '0;
                    n_cnt   = '0;
                    n_has   = 1'b0;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_plen      <= LENGTH_BITS'(1);
            r_cnt       <= '0;
            r_has       <= 1'b0;
            r_lines     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                    CFG_PATTERN_LENGTH: r_plen    <= i_cfg_data[LENGTH_BITS-1:0];
                    default:            r_plen    <= r_plen;
                endcase
            end
            r_cnt       <= n_cnt;
            r_has       <= n_has;
            r_lines     <= n_lines;
            r_out_valid <= n_out_valid;
        end
        r_win      <= n_win;
        r_out_line <= n_out_line;
    end

endmodule

/* src/line_word_search_top.sv */
// Top level of the line word search block.
`timescale 1ns / 1ps
// This block scans a text stream, one byte per word, for a fixed pattern of 1 to
// MAX_PATTERN_BYTES bytes held in the configuration registers, and for every line
// (ended by byte 10) that holds the pattern at least once it returns that line's
// number, counted from 1. An end-of-input word closes a non-empty unterminated last
// line and then clears the line state including the line counter, which otherwise
// saturates at its maximum. It takes one word per clock cycle on both sides while
// the output is not stalled: a classifying front register feeds a four-entry queue,
// and the back end updates its byte window and compares every pattern length in
// parallel, so a word passes through the front register and the queue before it
// reaches the result register. While a line number waits on the output the back
// end holds, and the queue and the front register take up to five more words
// before the input stalls. Configuration writes take effect at once and are only to
// be made while no word is in flight.
module line_word_search_top #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int LINE_COUNT_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic [7:0]                           i_text_byte,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [lws_pkg::LINE_NUMBER_BITS-1:0] o_line_number,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [lws_pkg::PATTERN_BITS-1:0]     i_cfg_data
);
    import lws_pkg::*;

    // Front to queue.
    logic     push;
    t_op_word push_word;
    logic     push_ready;

    // Queue to back.
    logic     q_valid;
    t_op_word q_word;
    logic     q_pop;

    lws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_text_byte  (i_text_byte),
        .o_push       (push),
        .o_word       (push_word),
        .i_push_ready (push_ready)
    );

    lws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_word       (push_word),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_word       (q_word),
        .i_pop        (q_pop)
    );

    lws_back #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LINE_COUNT_BITS   (LINE_COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_word      (q_word),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_line_number (o_line_number)
    );

endmodule

/* tb/sv/line_word_search_top_test.sv */
// Self-checking testbench for the line word search block, with its scoreboard.
`timescale 1ns / 1ps

// Scoreboard: predicts, for every accepted word, which line numbers the block must
// return, and compares each returned line number with the oldest one predicted.
class line_match_scoreboard;
    logic [63:0] pattern  = '0;
    logic [3:0]  pat_len  = 4'd1;

    logic [63:0] window   = '0;
    int          line_fill = 0;
    bit          line_hit = 1'b0;
    logic [31:0] line_count = '0;

    logic [31:0] expected_lines[$];
    int          mismatches = 0;

    function int effective_length();
        if (pat_len < 1) return 1;
        if (pat_len > 8) return 8;
        return int'(pat_len);
    endfunction

    function int pending();
        return expected_lines.size();
    endfunction

    function void write_register(logic idx, logic [63:0] data);
        if (idx == lws_pkg::CFG_PATTERN_BYTES) begin
            pattern = data;
        end else begin
            pat_len = data[3:0];
        end
    endfunction

    function void clear_line();
        window = '0;
        line_fill = 0;
        line_hit = 1'b0;
    endfunction

    function void close_line();
        if (line_count != 32'hFFFF_FFFF) line_count++;
        if (line_hit) expected_lines.push_back(line_count);
        clear_line();
    endfunction

    function void note_word(logic kind, logic [7:0] text_byte);
        int          len;
        logic [63:0] tail;
        logic [63:0] pmask;
        if (kind == lws_pkg::KIND_END) begin
            if (line_fill != 0) close_line();
            clear_line();
            line_count = '0;
            return;
        end
        if (text_byte == lws_pkg::NEWLINE_BYTE) begin
            close_line();
            return;
        end
        window = {text_byte, window[63:8]};
        if (line_fill < 8) line_fill++;
        len = effective_length();
        tail = window >> (8 * (8 - len));
        pmask = {64{1'b1}} >> (64 - 8 * len);
        if (line_fill >= len && tail == (pattern & pmask)) line_hit = 1'b1;
    endfunction

    function void check_line_number(logic [31:0] actual);
        logic [31:0] want;
        if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected line number %0d, none was predicted", actual);
            return;
        end
        want = expected_lines.pop_front();
        if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("line number mismatch: expected %0d, got %0d", want, actual);
        end
    endfunction
endclass

module line_word_search_top_test;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = lws_pkg::KIND_TEXT;
    logic [7:0]  i_text_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_line_number;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = lws_pkg::CFG_PATTERN_BYTES;
    logic [63:0] i_cfg_data = '0;

    line_match_scoreboard sb = new();

    // Sender bookkeeping: words left in the current burst and words accepted so far.
    int burst_left = 0;
    int words_sent = 0;

    // Receiver stall pattern state.
    int ready_mode = 0;
    int ready_hold = 0;
    int mode_timer = 0;

    line_word_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_text_byte   (i_text_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_line_number (o_line_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A generous limit: it leaves room for every gap and stall at its longest, so it
    // only fires on a hang.
    initial begin
        #2000000;
        $display("line_word_search_top_test: done, errors");
        $finish;
    end

    // Receiver. The stall pattern is redrawn at random, over and over, among always
    // ready, a coin toss per cycle, and alternating runs of ready and long stalls.
    initial begin
        forever begin
            @(negedge i_clk);
            mode_timer++;
            if (mode_timer >= 300) begin
                mode_timer = 0;
                ready_mode = $urandom_range(0, 2);
            end
            if (ready_hold == 0) begin
                case (ready_mode)
                    0: begin
                        i_ready = 1'b1;
                        ready_hold = $urandom_range(1, 50);
                    end
                    1: begin
                        i_ready = 1'($urandom_range(0, 1));
                        ready_hold = 1;
                    end
                    default: begin
                        i_ready = ~i_ready;
                        ready_hold = i_ready ? $urandom_range(1, 6) : $urandom_range(1, 16);
                    end
                endcase
            end
            ready_hold--;
        end
    end

    // Every line number taken from the block is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_line_number(o_line_number);
    end

    // Sends one word. Words go out in bursts; between bursts valid drops for a random
    // gap, which is sometimes empty so that long stretches run without any idling.
    task automatic send_word(logic kind, logic [7:0] text_byte);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_kind = kind;
        i_text_byte = text_byte;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(kind, text_byte);
        words_sent++;
    endtask

    // Stops sending and waits until every predicted line number has come back, and
    // then waits longer, since a word that yields no line number may still be in the
    // three-stage pipe when the last line number leaves.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_register(idx, data);
    endtask

    // Sends one line built mostly from the pattern: whole copies of it, broken
    // prefixes, single pattern bytes and a little random noise. Most lines end in a
    // newline; some are closed by an end of input, and some newlines are followed by
    // an end of input so that the empty final line gets exercised.
    task automatic send_text_line();
        int          segs;
        int          r;
        int          len;
        int          part;
        logic [63:0] pat;
        len = sb.effective_length();
        pat = sb.pattern;
        segs = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 6);
        for (int s = 0; s < segs; s++) begin
            r = $urandom_range(0, 9);
            if (r <= 2) begin
                for (int k = 0; k < len; k++) send_word(lws_pkg::KIND_TEXT, pat[8*k +: 8]);
            end else if (r == 3) begin
                part = $urandom_range(0, len - 1);
                for (int k = 0; k < part; k++) send_word(lws_pkg::KIND_TEXT, pat[8*k +: 8]);
            end else if (r <= 7) begin
                send_word(lws_pkg::KIND_TEXT, pat[8*$urandom_range(0, len - 1) +: 8]);
            end else begin
                send_word(lws_pkg::KIND_TEXT, 8'($urandom_range(0, 255)));
            end
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            send_word(lws_pkg::KIND_END, 8'($urandom_range(0, 255)));
        end else begin
            send_word(lws_pkg::KIND_TEXT, lws_pkg::NEWLINE_BYTE);
            if (r == 1) send_word(lws_pkg::KIND_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // One setting of the registers, written while the block is idle, followed by
    // random lines. Halfway through, the sender holds off until the block has
    // returned everything it owes.
    task automatic run_phase(logic [63:0] pattern, logic [3:0] length, int count);
        int  first;
        bit  paused;
        drain();
        write_register(lws_pkg::CFG_PATTERN_BYTES, pattern);
        write_register(lws_pkg::CFG_PATTERN_LENGTH, {60'd0, length});
        first = words_sent;
        paused = 1'b0;
        while (words_sent - first < count) begin
            send_text_line();
            if (!paused && words_sent - first >= count / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    // A pattern whose bytes come from a small random alphabet, so that random text
    // over the same alphabet matches often.
    function automatic logic [63:0] alphabet_pattern();
        logic [7:0]  letters[3];
        logic [63:0] pat;
        foreach (letters[i]) letters[i] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 8; k++) pat[8*k +: 8] = letters[$urandom_range(0, 2)];
        return pat;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with the registers as reset left them: the pattern is a
        // single zero byte. End of input at the very start closes nothing.
        send_word(lws_pkg::KIND_END, 8'h00);
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_TEXT, 8'hFF);
        send_word(lws_pkg::KIND_TEXT, lws_pkg::NEWLINE_BYTE);
        // An empty line that holds nothing.
        send_word(lws_pkg::KIND_TEXT, lws_pkg::NEWLINE_BYTE);
        // Several matches in one line must give its number only once.
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_TEXT, lws_pkg::NEWLINE_BYTE);
        // An unterminated last line is closed by end of input, whose byte is ignored.
        send_word(lws_pkg::KIND_TEXT, 8'h55);
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_END, lws_pkg::NEWLINE_BYTE);
        // The line counter restarts from one after end of input.
        send_word(lws_pkg::KIND_TEXT, 8'hAA);
        send_word(lws_pkg::KIND_TEXT, 8'h00);
        send_word(lws_pkg::KIND_TEXT, lws_pkg::NEWLINE_BYTE);
        // End of input right after a newline closes no further line.
        send_word(lws_pkg::KIND_END, 8'hFF);
        send_word(lws_pkg::KIND_TEXT, 8'h01);
        send_word(lws_pkg::KIND_END, 8'h00);

        // Random part over several register settings, the extremes among them:
        // lengths of one and eight, zero acting as one, nine and fifteen acting as
        // eight, and patterns of all zeros and all ones.
        run_phase(64'h0, 4'd8, 145);
        run_phase({64{1'b1}}, 4'd8, 145);
        run_phase(alphabet_pattern(), 4'd1, 145);
        run_phase(alphabet_pattern(), 4'd0, 145);
        run_phase(alphabet_pattern(), 4'd15, 145);
        run_phase(alphabet_pattern(), 4'd9, 145);
        run_phase(alphabet_pattern(), 4'd3, 145);
        run_phase(alphabet_pattern(), 4'd5, 145);
        run_phase({$urandom, $urandom}, 4'd2, 145);
        run_phase(alphabet_pattern(), 4'd7, 145);
        run_phase(alphabet_pattern(), 4'd8, 145);

        drain();
        if (sb.mismatches == 0) begin
            $display("line_word_search_top_test: done, clean");
        end else begin
            $display("line_word_search_top_test: done, errors");
        end
        $finish;
    end
endmodule
